FILE: rtl/ensemble_pvalue_minimum_search_assert.svh
// assertion macros for the ensemble p-value minimum search
`ifndef ENSEMBLE_PVALUE_MINIMUM_SEARCH_ASSERT_SVH
`define ENSEMBLE_PVALUE_MINIMUM_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define EPMS_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("epms check failed");
`define EPMS_CHECK_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
    else $error("epms check failed");
`else
`define EPMS_CHECK(lbl, prop)
`define EPMS_CHECK_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/epms_pkg.sv
// shared types and constants for the ensemble p-value minimum search
package epms_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_MAX_SIMS   = 64;
    localparam int DEF_MAX_SEARCH = 1024;

    localparam int NP_W = 13;
    localparam int NS_W = 7;
    localparam int NQ_W = 17;

    localparam logic signed [15:0] MINUS_ONE      = -16'sd16384;
    localparam logic signed [15:0] NEAR_MINUS_ONE = -16'sd16368;

    typedef enum logic [1:0] {
        CMD_GRID  = 2'd0,
        CMD_CURVE = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_POINTS = 3'd0,
        REG_SIMS   = 3'd1,
        REG_SEARCH = 3'd2,
        REG_START  = 3'd3,
        REG_END    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [NP_W-1:0]   np;
        logic [NS_W-1:0]   ns;
        logic [NQ_W-1:0]   nq;
        logic signed [15:0] start;
        logic signed [15:0] stop;
    } cfg_t;

    typedef struct packed {
        logic [NS_W-1:0]    cnt;
        logic signed [15:0] x;
    } best_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GF_A,
        S_GL_A,
        S_GL_D,
        S_XMUL,
        S_XDIV_GO,
        S_XDIV_W,
        S_RANGE,
        S_SCAN_A,
        S_SCAN_D,
        S_SEG_A,
        S_SEG_B,
        S_SEG_D,
        S_CRV_A,
        S_CRV_B,
        S_CRV_D,
        S_CRV_MUL,
        S_CRV_DIV,
        S_CRV_W,
        S_CNT_S,
        S_CNT_SD,
        S_CNT_A,
        S_CNT_D,
        S_BEST_A,
        S_BEST_D,
        S_OUT_A,
        S_OUT_D
    } state_t;

endpackage

FILE: rtl/ensemble_pvalue_minimum_search.sv
// Ensemble p-value minimum search.
// Commands arrive on start/busy: a command is taken when start is high and busy is low.
// cmd 0 writes grid_x at point_index, cmd 1 writes curve_value for sim_index at
// point_index; loads never raise busy, so one load per cycle.
// cmd 2 runs the search: busy is high from the cycle after the run is taken until the
// last result goes out, so a new command can be taken in that last result's cycle.
// A run first fetches the grid ends, then per search point computes the search x and
// checks its range (serial divider, NW = 51 at default sizes). On the grid, it scans for
// the segment and fetches its ends, interpolates each curve (no division on a flat
// segment), then counts and updates the minimum; off the grid only the minimum update
// runs. Curves, grid, per-curve values and the running minimum each live in a
// one-port-read ram, which sets the per-step cost.
// Results come out one per simulation in order, each on strobe for one cycle, with
// last on the final one; the receiver cannot stall, results must be taken as shown.
// Registers (APB, byte address 4*i): point_count, sim_count, search_count,
// search_start, search_end; write them only while busy is low.
// Reset clears control state and returns the registers to their defaults; table contents are undefined until loaded.
module ensemble_pvalue_minimum_search #(
    parameter int MAX_POINTS = epms_pkg::DEF_MAX_POINTS,
    parameter int MAX_SIMS   = epms_pkg::DEF_MAX_SIMS,
    parameter int MAX_SEARCH = epms_pkg::DEF_MAX_SEARCH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [7:0]         point_index,
    input  logic [5:0]         sim_index,
    input  logic signed [15:0] grid_x,
    input  logic signed [31:0] curve_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic               strobe,
    output logic [5:0]         out_sim,
    output logic [6:0]         under_count,
    output logic signed [15:0] best_x,
    output logic               range_error,
    output logic               last
);
    import epms_pkg::*;

    `include "ensemble_pvalue_minimum_search_assert.svh"

    localparam int PW   = $clog2(MAX_POINTS);
    localparam int SIW  = (MAX_SIMS > 1) ? $clog2(MAX_SIMS) : 1;
    localparam int CD   = MAX_SIMS * MAX_POINTS;
    localparam int CAW  = $clog2(CD);
    localparam int NQW  = $clog2(MAX_SEARCH);
    localparam int DW   = ((NQW + 2 > 18) ? NQW + 2 : 18) + 1;
    localparam int XNW  = NQW + 20;
    localparam int NW   = (XNW > 51) ? XNW : 51;
    localparam int VW   = NW + 2;
    localparam int BW   = NS_W + 16;

    cfg_t cfg;

    epms_cfg #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_SIMS   (MAX_SIMS),
        .MAX_SEARCH (MAX_SEARCH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;

    logic [NQW-1:0]     n_reg;
    logic [PW-1:0]      i_reg;
    logic [PW-1:0]      hi_reg;
    logic [SIW-1:0]     c_reg;
    logic [SIW-1:0]     s_reg;
    logic [NS_W-1:0]    cnt_reg;
    logic               err_reg;
    logic               oor_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] g0_reg;
    logic signed [15:0] gl_reg;
    logic signed [15:0] ghi_reg;
    logic signed [15:0] glo_reg;
    logic signed [31:0] yh_reg;
    logic signed [31:0] yl_reg;
    logic signed [NW-1:0] xnum_reg;
    logic signed [NW-1:0] prod_reg;
    logic signed [VW-1:0] vs_reg;

    logic               strobe_reg;
    logic [5:0]         out_sim_reg;
    logic [6:0]         under_count_reg;
    logic signed [15:0] best_x_reg;
    logic               range_error_reg;
    logic               last_reg;

    // ram ports
    logic            grid_we;
    logic [PW-1:0]   grid_waddr;
    logic [PW-1:0]   grid_raddr;
    logic [15:0]     grid_rdata;
    logic            curve_we;
    logic [CAW-1:0]  curve_waddr;
    logic [CAW-1:0]  curve_raddr;
    logic [31:0]     curve_rdata;
    logic            vals_we;
    logic [SIW-1:0]  vals_raddr;
    logic [VW-1:0]   vals_wdata;
    logic [VW-1:0]   vals_rdata;
    logic            best_we;
    logic [SIW-1:0]  best_raddr;
    best_t           best_wdata;
    logic [BW-1:0]   best_rdata;
    best_t           best_rd;

    logic                 div_start;
    logic signed [NW-1:0] div_num;
    logic signed [DW-1:0] div_den;
    logic                 div_done;
    logic signed [NW:0]   div_quo;

    logic                   take;
    logic [PW+7:0]          pi_ext;
    logic [SIW+5:0]         si_ext;
    logic                   pi_ok;
    logic                   si_ok;
    logic [NP_W-1:0]        np_m1;
    logic [NP_W-1:0]        np_m2;
    logic [NS_W-1:0]        ns_m1;
    logic [NQ_W-1:0]        nq_m1;
    logic                   c_last;
    logic                   s_last;
    logic                   n_last;
    logic                   scan_end;
    logic                   scan_hit;
    logic                   oor;
    logic signed [16:0]     delta;
    logic signed [NQW+17:0] dn_prod;
    logic signed [NW-1:0]   xnum;
    logic signed [16:0]     seg_d;
    logic signed [16:0]     seg_dx;
    logic signed [32:0]     seg_dy;
    logic signed [49:0]     yprod;
    logic signed [VW-1:0]   yh_ext;
    logic signed [VW-1:0]   interp;
    logic                   le;
    logic                   upd;

    assign busy = (state_reg != S_IDLE);
    assign take = start && !busy;

    assign pi_ext = {{PW{1'b0}}, point_index};
    assign si_ext = {{SIW{1'b0}}, sim_index};
    assign pi_ok  = pi_ext < (PW+8)'(MAX_POINTS);
    assign si_ok  = si_ext < (SIW+6)'(MAX_SIMS);

    assign np_m1 = cfg.np - NP_W'(1);
    assign np_m2 = cfg.np - NP_W'(2);
    assign ns_m1 = cfg.ns - NS_W'(1);
    assign nq_m1 = cfg.nq - NQ_W'(1);

    assign c_last   = NS_W'(c_reg) == ns_m1;
    assign s_last   = NS_W'(s_reg) == ns_m1;
    assign n_last   = NQ_W'(n_reg) == nq_m1;
    assign scan_end = NP_W'(i_reg) == np_m2;
    assign scan_hit = x_reg >= $signed(grid_rdata);
    assign oor      = (x_reg > g0_reg) || (x_reg < gl_reg);

    // numerator of the rounded search step: 2*delta*n + (nq-1)
    assign delta   = $signed({cfg.stop[15], cfg.stop}) - $signed({cfg.start[15], cfg.start});
    assign dn_prod = delta * $signed({1'b0, n_reg});
    assign xnum    = $signed({{(NW-NQW-19){dn_prod[NQW+17]}}, dn_prod, 1'b0})
                   + $signed({{(NW-NQ_W){1'b0}}, nq_m1});

    assign seg_d  = $signed({ghi_reg[15], ghi_reg}) - $signed({glo_reg[15], glo_reg});
    assign seg_dx = $signed({x_reg[15], x_reg}) - $signed({ghi_reg[15], ghi_reg});
    assign seg_dy = $signed({yh_reg[31], yh_reg}) - $signed({yl_reg[31], yl_reg});
    assign yprod  = seg_dy * seg_dx;
    assign yh_ext = $signed({{(VW-32){yh_reg[31]}}, yh_reg});
    assign interp = yh_ext + $signed({div_quo[NW], div_quo});

    assign best_rd = best_t'(best_rdata);
    assign le      = $signed(vals_rdata) <= vs_reg;
    assign upd     = (n_reg == '0) || ((cnt_reg < best_rd.cnt) && (x_reg > NEAR_MINUS_ONE));

    epms_ram #(.WIDTH(16), .DEPTH(MAX_POINTS), .AW(PW)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_x),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    epms_ram #(.WIDTH(32), .DEPTH(CD), .AW(CAW)) u_curve (
        .clk   (clk),
        .we    (curve_we),
        .waddr (curve_waddr),
        .wdata (curve_value),
        .raddr (curve_raddr),
        .rdata (curve_rdata)
    );

    epms_ram #(.WIDTH(VW), .DEPTH(MAX_SIMS), .AW(SIW)) u_vals (
        .clk   (clk),
        .we    (vals_we),
        .waddr (c_reg),
        .wdata (vals_wdata),
        .raddr (vals_raddr),
        .rdata (vals_rdata)
    );

    epms_ram #(.WIDTH(BW), .DEPTH(MAX_SIMS), .AW(SIW)) u_best (
        .clk   (clk),
        .we    (best_we),
        .waddr (s_reg),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    epms_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && (cmd == CMD_RUN))
                    state_next = S_GF_A;
            end
            S_GF_A:    state_next = S_GL_A;
            S_GL_A:    state_next = S_GL_D;
            S_GL_D:    state_next = S_XMUL;
            S_XMUL:    state_next = S_XDIV_GO;
            S_XDIV_GO: state_next = S_XDIV_W;
            S_XDIV_W:
            begin
                if (div_done)
                    state_next = S_RANGE;
            end
            S_RANGE:   state_next = oor ? S_CNT_S : S_SCAN_A;
            S_SCAN_A:  state_next = S_SCAN_D;
            S_SCAN_D:  state_next = (scan_hit || scan_end) ? S_SEG_A : S_SCAN_A;
            S_SEG_A:   state_next = S_SEG_B;
            S_SEG_B:   state_next = S_SEG_D;
            S_SEG_D:   state_next = S_CRV_A;
            S_CRV_A:   state_next = S_CRV_B;
            S_CRV_B:   state_next = S_CRV_D;
            S_CRV_D:   state_next = S_CRV_MUL;
            S_CRV_MUL: state_next = S_CRV_DIV;
            S_CRV_DIV:
            begin
                if (seg_d != '0)
                    state_next = S_CRV_W;
                else
                    state_next = c_last ? S_CNT_S : S_CRV_A;
            end
            S_CRV_W:
            begin
                if (div_done)
                    state_next = c_last ? S_CNT_S : S_CRV_A;
            end
            S_CNT_S:   state_next = oor_reg ? S_BEST_A : S_CNT_SD;
            S_CNT_SD:  state_next = S_CNT_A;
            S_CNT_A:   state_next = S_CNT_D;
            S_CNT_D:   state_next = c_last ? S_BEST_A : S_CNT_A;
            S_BEST_A:  state_next = S_BEST_D;
            S_BEST_D:
            begin
                if (!s_last)
                    state_next = S_CNT_S;
                else
                    state_next = n_last ? S_OUT_A : S_XMUL;
            end
            S_OUT_A:   state_next = S_OUT_D;
            S_OUT_D:   state_next = s_last ? S_IDLE : S_OUT_A;
            default:   state_next = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb
    begin
        grid_we     = take && (cmd == CMD_GRID) && pi_ok;
        grid_waddr  = pi_ext[PW-1:0];
        curve_we    = take && (cmd == CMD_CURVE) && pi_ok && si_ok;
        curve_waddr = CAW'(si_ext[SIW-1:0]) * CAW'(MAX_POINTS) + CAW'(pi_ext[PW-1:0]);
        grid_raddr  = i_reg;
        curve_raddr = CAW'(c_reg) * CAW'(MAX_POINTS) + CAW'(hi_reg);
        vals_raddr  = c_reg;
        vals_we     = 1'b0;
        vals_wdata  = interp;
        best_raddr  = s_reg;
        best_we     = 1'b0;
        best_wdata  = '{cnt: cnt_reg, x: x_reg};
        div_start   = 1'b0;
        div_num     = prod_reg;
        div_den     = $signed({{(DW-17){seg_d[16]}}, seg_d});
        unique case (state_reg)
            S_GF_A:    grid_raddr = '0;
            S_GL_A:    grid_raddr = np_m1[PW-1:0];
            S_SEG_A:   grid_raddr = hi_reg;
            S_SEG_B:   grid_raddr = hi_reg + 1'b1;
            S_CRV_B:   curve_raddr = CAW'(c_reg) * CAW'(MAX_POINTS) + CAW'(hi_reg) + CAW'(1);
            S_XDIV_GO:
            begin
                div_start = 1'b1;
                div_num   = xnum_reg;
                div_den   = $signed({{(DW-NQ_W-1){1'b0}}, nq_m1, 1'b0});
            end
            S_CRV_DIV:
            begin
                if (seg_d != '0)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    vals_we    = 1'b1;
                    vals_wdata = yh_ext;
                end
            end
            S_CRV_W:   vals_we = div_done;
            S_CNT_S:   vals_raddr = s_reg;
            S_BEST_D:  best_we = upd;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            n_reg      <= '0;
            i_reg      <= '0;
            c_reg      <= '0;
            s_reg      <= '0;
            err_reg    <= 1'b0;
            oor_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_OUT_D);
            last_reg   <= (state_reg == S_OUT_D) && s_last;
            unique case (state_reg)
                S_IDLE:
                begin
                    n_reg   <= '0;
                    s_reg   <= '0;
                    err_reg <= 1'b0;
                end
                S_RANGE:
                begin
                    oor_reg <= oor;
                    err_reg <= err_reg || oor;
                    i_reg   <= '0;
                    s_reg   <= '0;
                end
                S_SCAN_D:
                begin
                    if (!(scan_hit || scan_end))
                        i_reg <= i_reg + 1'b1;
                end
                S_SEG_D:   c_reg <= '0;
                S_CRV_DIV:
                begin
                    if ((seg_d == '0) && !c_last)
                        c_reg <= c_reg + 1'b1;
                end
                S_CRV_W:
                begin
                    if (div_done && !c_last)
                        c_reg <= c_reg + 1'b1;
                end
                S_CNT_SD:  c_reg <= '0;
                S_CNT_D:
                begin
                    if (!c_last)
                        c_reg <= c_reg + 1'b1;
                end
                S_BEST_D:
                begin
                    if (s_last)
                    begin
                        s_reg <= '0;
                        n_reg <= n_reg + 1'b1;
                    end
                    else
                    begin
                        s_reg <= s_reg + 1'b1;
                    end
                end
                S_OUT_D:   s_reg <= s_reg + 1'b1;
                default:   ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_GL_A:    g0_reg <= $signed(grid_rdata);
            S_GL_D:    gl_reg <= $signed(grid_rdata);
            S_XMUL:    xnum_reg <= xnum;
            S_XDIV_W:
            begin
                // the search x always lies between start and end
                if (div_done)
                    x_reg <= cfg.start + $signed(div_quo[15:0]);
            end
            S_SCAN_D:  hi_reg <= i_reg;
            S_SEG_B:   ghi_reg <= $signed(grid_rdata);
            S_SEG_D:   glo_reg <= $signed(grid_rdata);
            S_CRV_B:   yh_reg <= $signed(curve_rdata);
            S_CRV_D:   yl_reg <= $signed(curve_rdata);
            S_CRV_MUL: prod_reg <= $signed({{(NW-50){yprod[49]}}, yprod});
            S_CNT_S:
            begin
                // off the grid every curve counts as equal, so each count is the sim count
                if (oor_reg)
                    cnt_reg <= cfg.ns;
            end
            S_CNT_SD:
            begin
                vs_reg  <= $signed(vals_rdata);
                cnt_reg <= '0;
            end
            S_CNT_D:
            begin
                if (le)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            S_OUT_D:
            begin
                out_sim_reg     <= 6'(s_reg);
                under_count_reg <= best_rd.cnt;
                best_x_reg      <= best_rd.x;
                range_error_reg <= err_reg;
            end
            default:   ;
        endcase
    end

    assign strobe      = strobe_reg;
    assign out_sim     = out_sim_reg;
    assign under_count = under_count_reg;
    assign best_x      = best_x_reg;
    assign range_error = range_error_reg;
    assign last        = last_reg;

    `EPMS_CHECK(a_last_has_strobe, last |-> strobe)
    `EPMS_CHECK(a_final_result_frees, (strobe && last) |-> (state_reg == S_IDLE))
    `EPMS_CHECK(a_loads_only_idle, (grid_we || curve_we) |-> (state_reg == S_IDLE))
    `EPMS_CHECK(a_div_waits, (state_reg == S_XDIV_W) |=> (state_reg == S_XDIV_W || state_reg == S_RANGE))

endmodule

FILE: rtl/epms_ram.sv
// generic simple dual-port ram with registered read
module epms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/epms_div.sv
// bit-serial signed floor divider
module epms_div #(
    parameter int NW = 51,
    parameter int DW = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [NW:0]   quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] a_reg;
    logic [DW-1:0] b_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          neg_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          fits;
    logic [NW:0]   qmag;

    assign trial = {rem_reg, a_reg[NW-1]};
    assign fits  = trial >= {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= num[NW-1] ? (~num + 1'b1) : num;
            b_reg   <= den[DW-1] ? (~den + 1'b1) : den;
            rem_reg <= '0;
            neg_reg <= num[NW-1] ^ den[DW-1];
        end
        else if (run_reg)
        begin
            // quotient bits shift in where dividend bits shift out
            rem_reg <= fits ? DW'(trial - {1'b0, b_reg}) : trial[DW-1:0];
            a_reg   <= {a_reg[NW-2:0], fits};
        end
    end

    assign qmag = {1'b0, a_reg};
    assign quo  = neg_reg ? $signed(~qmag + 1'b1 - {{NW{1'b0}}, (rem_reg != '0)})
                          : $signed(qmag);
    assign done = done_reg;

endmodule

FILE: rtl/epms_cfg.sv
// configuration registers behind the apb port, with range clamping
module epms_cfg #(
    parameter int MAX_POINTS = epms_pkg::DEF_MAX_POINTS,
    parameter int MAX_SIMS   = epms_pkg::DEF_MAX_SIMS,
    parameter int MAX_SEARCH = epms_pkg::DEF_MAX_SEARCH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output epms_pkg::cfg_t cfg
);
    import epms_pkg::*;

    logic [8:0]         points_reg;
    logic [6:0]         sims_reg;
    logic [10:0]        search_reg;
    logic signed [15:0] start_reg;
    logic signed [15:0] end_reg;
    logic               wr;
    reg_idx_t           idx;
    logic [NP_W-1:0]    np_raw;
    logic [NQ_W-1:0]    nq_raw;

    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= 9'd2;
            sims_reg   <= 7'd1;
            search_reg <= 11'd2;
            start_reg  <= MINUS_ONE;
            end_reg    <= 16'sd16384;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_POINTS: points_reg <= pwdata[8:0];
                REG_SIMS:   sims_reg   <= pwdata[6:0];
                REG_SEARCH: search_reg <= pwdata[10:0];
                REG_START:  start_reg  <= pwdata[15:0];
                REG_END:    end_reg    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POINTS: prdata = {23'd0, points_reg};
            REG_SIMS:   prdata = {25'd0, sims_reg};
            REG_SEARCH: prdata = {21'd0, search_reg};
            REG_START:  prdata = {16'd0, start_reg};
            REG_END:    prdata = {16'd0, end_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign np_raw = {{(NP_W-9){1'b0}}, points_reg};
    assign nq_raw = {{(NQ_W-11){1'b0}}, search_reg};

    always_comb
    begin
        if (np_raw < NP_W'(2))
            cfg.np = NP_W'(2);
        else if (np_raw > NP_W'(MAX_POINTS))
            cfg.np = NP_W'(MAX_POINTS);
        else
            cfg.np = np_raw;

        if (sims_reg < NS_W'(1))
            cfg.ns = NS_W'(1);
        else if (sims_reg > NS_W'(MAX_SIMS))
            cfg.ns = NS_W'(MAX_SIMS);
        else
            cfg.ns = sims_reg;

        if (nq_raw < NQ_W'(2))
            cfg.nq = NQ_W'(2);
        else if (nq_raw > NQ_W'(MAX_SEARCH))
            cfg.nq = NQ_W'(MAX_SEARCH);
        else
            cfg.nq = nq_raw;

        // exact -1.0 would sit on the grid edge, use -0.999 instead
        cfg.start = (start_reg == MINUS_ONE) ? NEAR_MINUS_ONE : start_reg;
        cfg.stop  = end_reg;
    end

endmodule

FILE: test/ensemble_pvalue_minimum_search_checker.sv
// checker: predicts the per-simulation minima of each search run and compares them
`timescale 1ns / 100ps
module ensemble_pvalue_minimum_search_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         cmd,
    input  logic [7:0]         point_index,
    input  logic [5:0]         sim_index,
    input  logic signed [15:0] grid_x,
    input  logic signed [31:0] curve_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               strobe,
    input  logic [5:0]         out_sim,
    input  logic [6:0]         under_count,
    input  logic signed [15:0] best_x,
    input  logic               range_error,
    input  logic               last,
    output int                 fail_count,
    output int                 outstanding
);
    import epms_pkg::*;

    typedef struct {
        logic [5:0]         sim;
        logic [6:0]         cnt;
        logic signed [15:0] x;
        logic               err;
        logic               fin;
    } minimum_t;

    minimum_t expected_minima[$];

    logic signed [15:0] grid_mem [DEF_MAX_POINTS];
    logic signed [31:0] curve_mem [DEF_MAX_SIMS][DEF_MAX_POINTS];

    logic [8:0]         points_reg;
    logic [6:0]         sims_reg;
    logic [10:0]        search_reg;
    logic signed [15:0] start_reg;
    logic signed [15:0] end_reg;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && ((a < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic predict_minima();
        longint   vals [DEF_MAX_SIMS];
        int       best [DEF_MAX_SIMS];
        longint   bx [DEF_MAX_SIMS];
        bit       err;
        int       np, ns, nq, i, hi, lo, cnt;
        longint   st, en, x, d, yh, yl;
        minimum_t m;
        err = 0;
        np = clamp(points_reg, 2, DEF_MAX_POINTS);
        ns = clamp(sims_reg, 1, DEF_MAX_SIMS);
        nq = clamp(search_reg, 2, DEF_MAX_SEARCH);
        st = start_reg;
        en = end_reg;
        if (st == MINUS_ONE)
            st = NEAR_MINUS_ONE;
        for (int n = 0; n < nq; n++) begin
            x = st + floor_div(2 * (en - st) * n + (nq - 1), 2 * (nq - 1));
            if (x > grid_mem[0] || x < grid_mem[np-1]) begin
                err = 1;
                for (int c = 0; c < ns; c++)
                    vals[c] = -65536;
            end else begin
                for (i = 0; i < np - 1; i++)
                    if (x >= grid_mem[i])
                        break;
                // exact hit on the final grid x falls back to the last segment
                hi = (i >= np - 1) ? np - 2 : i;
                lo = hi + 1;
                d = longint'(grid_mem[hi]) - longint'(grid_mem[lo]);
                for (int c = 0; c < ns; c++) begin
                    yh = curve_mem[c][hi];
                    yl = curve_mem[c][lo];
                    vals[c] = (d == 0) ? yh : yh + floor_div((yh - yl) * (x - grid_mem[hi]), d);
                end
            end
            for (int s = 0; s < ns; s++) begin
                cnt = 0;
                for (int c = 0; c < ns; c++)
                    if (vals[c] <= vals[s])
                        cnt++;
                if (n == 0 || (cnt < best[s] && x > NEAR_MINUS_ONE)) begin
                    best[s] = cnt;
                    bx[s] = x;
                end
            end
        end
        for (int s = 0; s < ns; s++) begin
            m.sim = s[5:0];
            m.cnt = best[s][6:0];
            m.x = bx[s][15:0];
            m.err = err;
            m.fin = (s == ns - 1);
            expected_minima.push_back(m);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        minimum_t m;
        if (!rst_n)
        begin
            points_reg = 2;
            sims_reg = 1;
            search_reg = 2;
            start_reg = MINUS_ONE;
            end_reg = 16'sd16384;
            expected_minima.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_POINTS: points_reg = pwdata[8:0];
                    REG_SIMS:   sims_reg = pwdata[6:0];
                    REG_SEARCH: search_reg = pwdata[10:0];
                    REG_START:  start_reg = pwdata[15:0];
                    REG_END:    end_reg = pwdata[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (cmd_t'(cmd))
                    CMD_GRID:  grid_mem[point_index] = grid_x;
                    CMD_CURVE: curve_mem[sim_index][point_index] = curve_value;
                    CMD_RUN:   predict_minima();
                    default: ;
                endcase
            end
            if (strobe)
            begin
                if (expected_minima.size() == 0)
                    report_mismatch($sformatf("unexpected result for sim %0d", out_sim));
                else
                begin
                    m = expected_minima.pop_front();
                    if (out_sim !== m.sim)
                        report_mismatch($sformatf("out_sim %0d, want %0d", out_sim, m.sim));
                    if (under_count !== m.cnt)
                        report_mismatch($sformatf("sim %0d under_count %0d, want %0d",
                                                  m.sim, under_count, m.cnt));
                    if (best_x !== m.x)
                        report_mismatch($sformatf("sim %0d best_x %0d, want %0d",
                                                  m.sim, best_x, m.x));
                    if (range_error !== m.err)
                        report_mismatch($sformatf("sim %0d range_error %b, want %b",
                                                  m.sim, range_error, m.err));
                    if (last !== m.fin)
                        report_mismatch($sformatf("sim %0d last %b, want %b",
                                                  m.sim, last, m.fin));
                end
            end
            outstanding <= expected_minima.size();
        end
    end

endmodule

FILE: test/ensemble_pvalue_minimum_search_tb.sv
// testbench top: loads grids and curves, runs searches and gives the verdict
`timescale 1ns / 100ps
module ensemble_pvalue_minimum_search_tb;
    import epms_pkg::*;

    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int ITEM_TARGET = 420;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         cmd;
    logic [7:0]         point_index;
    logic [5:0]         sim_index;
    logic signed [15:0] grid_x;
    logic signed [31:0] curve_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               strobe;
    logic [5:0]         out_sim;
    logic [6:0]         under_count;
    logic signed [15:0] best_x;
    logic               range_error;
    logic               last;
    int                 fail_count;
    int                 outstanding;

    int                 cycles;
    int                 items_sent;
    int                 idle_pct;
    logic signed [15:0] grid_now [DEF_MAX_POINTS];
    int                 np_now;

    ensemble_pvalue_minimum_search dut (.*);
    ensemble_pvalue_minimum_search_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic issue(cmd_t c, logic [7:0] pi, logic [5:0] si,
                         logic signed [15:0] gx, logic signed [31:0] cv);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        point_index <= pi;
        sim_index <= si;
        grid_x <= gx;
        curve_value <= cv;
        do @(posedge clk); while (busy);
        items_sent++;
        if (items_sent > ITEM_TARGET / 3)
            idle_pct = (items_sent > 2 * ITEM_TARGET / 3) ? 0 : 80;
    endtask

    // waits out every pending result plus a short settle before register writes
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic noise();
        if ($urandom_range(0, 99) < 5)
            issue(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
    endtask

    function automatic logic signed [31:0] pick_curve();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd65536;
            3, 4, 5: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // grid_mode: 0 random decreasing, 1 full span, 2 random with flat segments
    task automatic load_tables(int np, int ns, int grid_mode);
        int step_max, g;
        step_max = $urandom_range(1, 32768 / (np - 1));
        g = -16384 + (np - 1) * step_max + $urandom_range(0, 32768 - (np - 1) * step_max);
        for (int i = 0; i < np; i++)
        begin
            if (grid_mode == 1)
                g = 16384 - (32768 * i) / (np - 1);
            else if (i > 0)
                g = g - $urandom_range((grid_mode == 2 && $urandom_range(0, 2) == 0) ? 0 : 1,
                                       step_max);
            grid_now[i] = g;
            issue(CMD_GRID, i, $urandom, g, $urandom);
            noise();
        end
        for (int s = 0; s < ns; s++)
            for (int i = 0; i < np; i++)
            begin
                issue(CMD_CURVE, i, s, $urandom, pick_curve());
                noise();
            end
    endtask

    // range_mode picks two ends: 0 random, 1 grid ends, 2 -1 and +1; start and end each take either end
    task automatic run_search(int range_mode);
        logic signed [15:0] st, en;
        drain();
        case (range_mode)
            1:
            begin
                st = grid_now[0];
                en = grid_now[np_now-1];
            end
            2:
            begin
                st = MINUS_ONE;
                en = 16'sd16384;
            end
            default:
            begin
                st = $signed($urandom_range(0, 32768)) - 16384;
                en = $signed($urandom_range(0, 32768)) - 16384;
            end
        endcase
        if ($urandom_range(0, 1))
            reg_write(REG_START, {16'h0, st});
        else
            reg_write(REG_START, {16'h0, en});
        reg_write(REG_END, {16'h0, $urandom_range(0, 1) ? st : en});
        issue(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic scenario(int np_reg, int ns_reg, int nq_reg, int runs, int grid_mode);
        int ns;
        drain();
        reg_write(REG_POINTS, np_reg);
        reg_write(REG_SIMS, ns_reg);
        reg_write(REG_SEARCH, nq_reg);
        np_now = np_reg < 2 ? 2 : (np_reg > DEF_MAX_POINTS ? DEF_MAX_POINTS : np_reg);
        ns = ns_reg < 1 ? 1 : (ns_reg > DEF_MAX_SIMS ? DEF_MAX_SIMS : ns_reg);
        load_tables(np_now, ns, grid_mode);
        for (int r = 0; r < runs; r++)
            run_search(r == 0 ? grid_mode : $urandom_range(0, 2));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_NONE;
        point_index = '0;
        sim_index = '0;
        grid_x = '0;
        curve_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_sent = 0;
        idle_pct = 19;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration straight away: full-span grid, start of -1 replaced
        np_now = 2;
        load_tables(2, 1, 1);
        issue(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
        issue(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
        run_search(1);

        // saturating register values and special grids
        scenario(0, 0, 0, 2, 1);
        scenario(4, 4, 1, 2, 2);
        // sim count above the limit, on the smallest grid
        scenario(2, 127, 2, 2, 1);
        // search count above the limit with few curves
        scenario(3, 2, 2047, 0, 1);
        run_search(1);
        drain();
        reg_write(REG_SEARCH, 2);
        run_search(2);
        scenario(6, 3, 1024, 1, 1);

        while (items_sent < ITEM_TARGET)
            scenario($urandom_range(2, 12), $urandom_range(1, 8), $urandom_range(2, 16),
                     $urandom_range(1, 3), $urandom_range(0, 2));

        drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
